// ----- hw/rtl/prbs32fc_pkg.sv -----
// ----------------------------------------------------------------------------
// prbs32fc_pkg
// Shared types, constants and the LFSR step function of the PRBS32 fragment
// checker.
// ----------------------------------------------------------------------------
package prbs32fc_pkg;

  // One request on the input channel: a word of the bank stream.
  typedef struct packed {
    logic [31:0] data_word;
    logic        last_of_bank;
  } in_item_t;

  // One request on the result channel.
  typedef struct packed {
    logic        checked;
    logic        mismatch;
    logic        type_error;
    logic [31:0] error_count;
    logic        bank_done;
  } out_item_t;

  // Fragment type field in word 1 of a fragment.
  localparam int unsigned TYPE_LSB    = 8;
  localparam int unsigned TYPE_W      = 6;
  localparam logic [5:0]  TYPE_UINT32 = 6'h01;

  // Seed position register.
  localparam logic [7:0]  SEED_RESET  = 8'd5;
  localparam logic [7:0]  MIN_SEED    = 8'd2;

  // Word positions with a fixed meaning inside a fragment.
  localparam logic [31:0] POS_HEADER  = 32'd0;
  localparam logic [31:0] POS_TYPE    = 32'd1;

  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

  // One step of the Fibonacci LFSR: taps 31, 6, 2 and 1, shifted left,
  // with the feedback entering bit 0.
  function automatic logic [31:0] prbs_next(input logic [31:0] x);
    logic fb;
    fb = x[31] ^ x[6] ^ x[2] ^ x[1];
    return {x[30:0], fb};
  endfunction

endpackage

// ----- hw/rtl/prbs32fc_in_stage.sv -----
// ----------------------------------------------------------------------------
// prbs32fc_in_stage
// Input register: holds one accepted word until the checker core takes it.
// ----------------------------------------------------------------------------
module prbs32fc_in_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  prbs32fc_pkg::in_item_t in_item,
  input  logic                   take,
  output logic                   held_valid,
  output prbs32fc_pkg::in_item_t held_item
);
  import prbs32fc_pkg::*;

  logic     vld_r;
  logic     vld_nxt;
  in_item_t item_r;

  // The register is free when empty or when its request moves on this cycle.
  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload register; no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign held_valid = vld_r;
  assign held_item  = item_r;

endmodule

// ----- hw/rtl/prbs32fc_core.sv -----
// ----------------------------------------------------------------------------
// prbs32fc_core
// Fragment tracking, type check, LFSR prediction and the per-bank mismatch
// count. Forms one result for each word it is stepped with.
// ----------------------------------------------------------------------------
module prbs32fc_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [7:0]              cfg_wdata,
  input  logic                    step,
  input  prbs32fc_pkg::in_item_t  item,
  output prbs32fc_pkg::out_item_t result
);
  import prbs32fc_pkg::*;

  logic [7:0]  seed_r;
  logic [31:0] pos_r,   pos_nxt;
  logic [31:0] hdr_r,   hdr_nxt;
  logic [31:0] exp_r,   exp_nxt;
  logic [31:0] tot_r,   tot_nxt;
  logic        bad_r,   bad_nxt;

  logic [7:0]  seed_eff;
  logic [31:0] seed_pos;
  logic [31:0] pred;
  logic [5:0]  frag_type;
  logic [32:0] pos_inc;
  logic        checked;
  logic        miss;
  logic        terr;

  // Seed positions below the first payload word act as the first payload word.
  assign seed_eff  = (seed_r < MIN_SEED) ? MIN_SEED : seed_r;
  assign seed_pos  = {24'd0, seed_eff};
  assign pred      = prbs_next(exp_r);
  assign frag_type = item.data_word[TYPE_LSB +: TYPE_W];
  assign pos_inc   = {1'b0, pos_r} + 33'd1;

  // Next state and result for the word in hand.
  always_comb begin
    hdr_nxt = hdr_r;
    exp_nxt = exp_r;
    tot_nxt = tot_r;
    bad_nxt = bad_r;
    checked = 1'b0;
    miss    = 1'b0;
    terr    = 1'b0;

    if (pos_r == POS_HEADER) begin
      // Header: the word holds the fragment length minus one.
      hdr_nxt = item.data_word;
      bad_nxt = 1'b0;
    end else if (pos_r == POS_TYPE) begin
      bad_nxt = (frag_type != TYPE_UINT32);
      terr    = bad_nxt;
    end else if (!bad_r) begin
      if (pos_r == seed_pos) begin
        exp_nxt = item.data_word;
      end else if (pos_r > seed_pos) begin
        exp_nxt = pred;
        checked = 1'b1;
        if (pred != item.data_word) begin
          miss = 1'b1;
          if (tot_r != COUNT_MAX) begin
            tot_nxt = tot_r + 32'd1;
          end
        end
      end
    end

    // Wrap to the next header once the fragment length is used up.
    if (pos_inc > {1'b0, hdr_nxt}) begin
      pos_nxt = POS_HEADER;
    end else begin
      pos_nxt = pos_inc[31:0];
    end

    result.checked     = checked;
    result.mismatch    = miss;
    result.type_error  = terr;
    result.error_count = tot_nxt;
    result.bank_done   = item.last_of_bank;

    // Bank end drops any partial fragment and clears the count.
    if (item.last_of_bank) begin
      pos_nxt = '0;
      hdr_nxt = '0;
      exp_nxt = '0;
      tot_nxt = '0;
      bad_nxt = 1'b0;
    end
  end

  // Seed position register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  // Checker state advances once per word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hdr_r <= '0;
      exp_r <= '0;
      tot_r <= '0;
      bad_r <= 1'b0;
    end else if (step) begin
      pos_r <= pos_nxt;
      hdr_r <= hdr_nxt;
      exp_r <= exp_nxt;
      tot_r <= tot_nxt;
      bad_r <= bad_nxt;
    end
  end

endmodule

// ----- hw/rtl/prbs32fc_out_stage.sv -----
// ----------------------------------------------------------------------------
// prbs32fc_out_stage
// Result register: holds a finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module prbs32fc_out_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  prbs32fc_pkg::out_item_t load_item,
  output logic                    can_load,
  output logic                    out_valid,
  input  logic                    out_ready,
  output prbs32fc_pkg::out_item_t out_item
);
  import prbs32fc_pkg::*;

  logic      vld_r;
  logic      vld_nxt;
  out_item_t item_r;

  // A new result may enter when the register is empty or is being drained.
  assign can_load = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = vld_r;
  assign out_item  = item_r;

endmodule

// ----- hw/rtl/prbs32_fragment_checker_unit.sv -----
// Flow: an accepted word waits in the input register until the result
// register can take it, and its result is then registered there.
// Throughput: one word per cycle while the consumer keeps out_ready high;
// the input and result registers form a two-entry pipeline, so one more
// word is taken while a result waits. Reset (synchronous, rst_n low): both
// registers empty, fragment and bank state cleared, seed position back to 5.
// ----------------------------------------------------------------------------
// prbs32_fragment_checker_unit
// PRBS32 checker for a bank of fragments: input register, checker core and
// result register.
// ----------------------------------------------------------------------------
module prbs32_fragment_checker_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  prbs32fc_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output prbs32fc_pkg::out_item_t out_item,
  input  logic                    cfg_we,
  input  logic [7:0]              cfg_wdata
);
  import prbs32fc_pkg::*;

  logic      held_valid;
  in_item_t  held_item;
  out_item_t core_result;
  logic      can_load;
  logic      step;

  // A held word is processed whenever the result register can take it.
  assign step = held_valid && can_load;

  prbs32fc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  prbs32fc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (held_item),
    .result    (core_result)
  );

  prbs32fc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .load_item (core_result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- hw/rtl/prbs32fc_sva.sv -----
// ----------------------------------------------------------------------------
// prbs32fc_sva
// Port-level checks for the PRBS32 fragment checker, bound to the top level.
// ----------------------------------------------------------------------------
module prbs32fc_sva (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input prbs32fc_pkg::out_item_t out_item
);
  import prbs32fc_pkg::*;

  // A mismatch is only reported on a word that was compared.
  a_miss_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.mismatch |-> out_item.checked)
    else $error("mismatch reported on an unchecked word");

  // The type word of a fragment is never compared against the prediction.
  a_type_err_unchecked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.type_error |-> !out_item.checked)
    else $error("type error on a checked word");

  // A mismatch always leaves the saturating count above zero.
  a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.mismatch |-> out_item.error_count != '0)
    else $error("mismatch not counted");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

endmodule

bind prbs32_fragment_checker_unit prbs32fc_sva u_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
